// ===== sv/cds_pkg.sv =====
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, constants and calendar functions for the date stepper.
// ----------------------------------------------------------------------------
package cds_pkg;

	localparam int DAY_W     = 5;
	localparam int MONTH_W   = 4;
	localparam int YEAR_W    = 14;
	localparam int COUNT_W   = 20;
	localparam int APART_W   = 22;
	localparam int SER_W     = 23;   // day number up to year 16383
	localparam int Q100_W    = 8;    // year / 100
	localparam int R100_W    = 7;    // year % 100
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	localparam int MAX_YEAR_DEF = 9999;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SH for x < 2^15
	localparam int RECIP_100 = 5243;
	localparam int RECIP_SH  = 19;
	localparam int PROD_W    = 27;

	// command codes carried on s_tuser
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ADD  = 2'd1,
		OP_SUB  = 2'd2,
		OP_DIFF = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	// year split as year = 100*q + r
	typedef struct packed {
		logic [Q100_W-1:0] q;
		logic [R100_W-1:0] r;
	} ydiv_t;

	function automatic logic is_leap(input logic [1:0] ylo, input ydiv_t dv);
		logic r_zero;
		r_zero = (dv.r == '0);
		return ((ylo == 2'd0) && !r_zero) || (r_zero && (dv.q[1:0] == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic leap,
			input logic [MONTH_W-1:0] month);
		logic [DAY_W-1:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// days in the months before this one
	function automatic logic [8:0] cum_days(input logic leap,
			input logic [MONTH_W-1:0] month);
		logic [8:0] base;
		case (month)
			4'd1:  base = 9'd0;
			4'd2:  base = 9'd31;
			4'd3:  base = 9'd59;
			4'd4:  base = 9'd90;
			4'd5:  base = 9'd120;
			4'd6:  base = 9'd151;
			4'd7:  base = 9'd181;
			4'd8:  base = 9'd212;
			4'd9:  base = 9'd243;
			4'd10: base = 9'd273;
			4'd11: base = 9'd304;
			4'd12: base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && (month > 4'd2)) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

// ===== sv/cds_div100.sv =====
// ----------------------------------------------------------------------------
// cds_div100
// Two-stage split of a year into year/100 and year%100 by reciprocal multiply.
// ----------------------------------------------------------------------------
module cds_div100
	import cds_pkg::*;
(
	input  logic              clk,
	input  logic [YEAR_W-1:0] year,
	output ydiv_t             dv
);

	logic [PROD_W-1:0] prod;
	logic [Q100_W-1:0] q_s1;
	logic [R100_W-1:0] r_s2;
	logic [YEAR_W-1:0] rem;

	assign prod = PROD_W'(year) * PROD_W'(RECIP_100);
	assign rem  = year - YEAR_W'(q_s1) * YEAR_W'(100);

	always_ff @(posedge clk) begin
		q_s1 <= Q100_W'(prod >> RECIP_SH);
		r_s2 <= rem[R100_W-1:0];
	end

	assign dv.q = q_s1;
	assign dv.r = r_s2;

endmodule

// ===== sv/cds_serial.sv =====
// ----------------------------------------------------------------------------
// cds_serial
// Day number of a date (1/1/0 is day 0), in two passes: year base, then month/day.
// ----------------------------------------------------------------------------
module cds_serial
	import cds_pkg::*;
(
	input  logic             clk,
	input  logic             base_en,   // capture year base this cycle
	input  date_t            date,
	input  ydiv_t            dv,
	output logic [SER_W-1:0] serial
);

	logic [YEAR_W:0]   y_p3;
	logic              r_nz;
	logic              exact400;
	logic [SER_W-1:0]  base_d;
	logic [SER_W-1:0]  base_q;
	logic              leap;

	assign y_p3     = {1'b0, date.year} + (YEAR_W+1)'(3);
	assign r_nz     = (dv.r != '0);
	assign exact400 = !r_nz && (dv.q[1:0] == 2'd0);

	// 365*y + ceil(y/4) - ceil(y/100) + ceil(y/400)
	assign base_d = SER_W'(date.year) * SER_W'(365) + SER_W'(y_p3[YEAR_W:2])
		- SER_W'(dv.q) - SER_W'(r_nz)
		+ SER_W'(dv.q[Q100_W-1:2]) + SER_W'(!exact400);

	always_ff @(posedge clk) begin
		if (base_en) begin
			base_q <= base_d;
		end
	end

	assign leap   = is_leap(date.year[1:0], dv);
	assign serial = base_q + SER_W'(cum_days(leap, date.month)) + SER_W'(date.day)
		- SER_W'(1);

endmodule

// ===== sv/calendar_date_stepper.sv =====
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Gregorian date register with load, add/subtract days and day distance.
// ----------------------------------------------------------------------------
// Holds one date (reset 1/1/0) and answers one result word per command word.
// The block takes one command at a time: s_tready is high only while idle,
// and a finished result waits in the output register while the next command
// is taken. Load and difference pass the divider and check states, and
// difference then runs the operand and held day-number passes unless the
// operand date is invalid; for add/subtract the day stepper moves the held
// date by one day per clock and stops early at 31/12/MAX_YEAR or 1/1/0. If
// the previous result is still waiting in the output register, the block
// holds in its output state until that word is taken. Year/100 and year%100 of
// the held date are carried as counters so the leap test needs no divider while
// stepping; for an operand year they come from a two-stage reciprocal multiply.
// ----------------------------------------------------------------------------
module calendar_date_stepper
	import cds_pkg::*;
#(
	parameter int MAX_YEAR = MAX_YEAR_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// in_day[4:0], in_month[8:5], in_year[22:9], step_count[42:23], zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	// opcode[1:0]
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// cur_day[4:0], cur_month[8:5], cur_year[22:9], days_apart[44:23], zero fill
	output logic [M_TDATA_W-1:0] m_tdata,
	// error_flag[0]
	output logic [0:0]           m_tuser
);

	localparam logic [YEAR_W-1:0] MaxYear = YEAR_W'(MAX_YEAR);

	typedef enum logic [3:0] {
		S_IDLE, S_DIVQ, S_DIVR, S_CHK, S_UP, S_DN,
		S_SO_A, S_SO_B, S_SH_A, S_SH_B, S_DIFF, S_OUT
	} state_t;

	state_t              state_q;
	opcode_t             op_q;
	date_t               opd_q;          // operand date
	logic [COUNT_W-1:0]  cnt_q;          // days left to step
	date_t               held_q;
	ydiv_t               hdv_q;          // held year split by 100
	logic                err_q;
	logic [APART_W-1:0]  apart_q;
	logic [SER_W-1:0]    so_q;           // operand day number
	logic [SER_W-1:0]    sh_q;           // held day number
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                m_err_q;

	ydiv_t               opd_dv;
	date_t               ser_date;
	ydiv_t               ser_dv;
	logic                ser_base_en;
	logic [SER_W-1:0]    ser_out;

	logic                held_leap;
	logic [DAY_W-1:0]    held_mlen;
	logic [DAY_W-1:0]    prev_mlen;
	logic                at_top;
	logic                at_bottom;
	logic                opd_leap;
	logic                opd_ok;
	logic [SER_W-1:0]    gap_days;

	assign s_tready = (state_q == S_IDLE);

	cds_div100 u_div (
		.clk  (clk),
		.year (opd_q.year),
		.dv   (opd_dv)
	);

	// shared day-number unit: operand first, then held date
	assign ser_base_en = (state_q == S_SO_A) || (state_q == S_SH_A);
	assign ser_date    = ((state_q == S_SO_A) || (state_q == S_SO_B)) ? opd_q : held_q;
	assign ser_dv      = ((state_q == S_SO_A) || (state_q == S_SO_B)) ? opd_dv : hdv_q;

	cds_serial u_ser (
		.clk     (clk),
		.base_en (ser_base_en),
		.date    (ser_date),
		.dv      (ser_dv),
		.serial  (ser_out)
	);

	// stepper decode on the held date
	assign held_leap = is_leap(held_q.year[1:0], hdv_q);
	assign held_mlen = month_len(held_leap, held_q.month);
	assign prev_mlen = month_len(held_leap, held_q.month - MONTH_W'(1));
	assign at_top    = (held_q.year == MaxYear) && (held_q.month == MONTH_W'(12))
		&& (held_q.day == DAY_W'(31));
	assign at_bottom = (held_q.year == '0) && (held_q.month == MONTH_W'(1))
		&& (held_q.day == DAY_W'(1));

	// operand check, valid once the divider has settled
	assign opd_leap = is_leap(opd_q.year[1:0], opd_dv);
	assign opd_ok   = (opd_q.month >= MONTH_W'(1)) && (opd_q.month <= MONTH_W'(12))
		&& (opd_q.year <= MaxYear) && (opd_q.day >= DAY_W'(1))
		&& (opd_q.day <= month_len(opd_leap, opd_q.month));

	assign gap_days = (so_q > sh_q) ? (so_q - sh_q) : (sh_q - so_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_LOAD;
			opd_q        <= '0;
			cnt_q        <= '0;
			held_q.year  <= '0;
			held_q.month <= MONTH_W'(1);
			held_q.day   <= DAY_W'(1);
			hdv_q        <= '0;
			err_q        <= 1'b0;
			apart_q      <= '0;
			so_q         <= '0;
			sh_q         <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_err_q      <= 1'b0;
		end else begin
			// the output state drives valid itself
			if (m_tready && (state_q != S_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q        <= opcode_t'(s_tuser);
						opd_q.day   <= s_tdata[4:0];
						opd_q.month <= s_tdata[8:5];
						opd_q.year  <= s_tdata[22:9];
						cnt_q       <= s_tdata[42:23];
						err_q       <= 1'b0;
						apart_q     <= '0;
						case (opcode_t'(s_tuser))
							OP_ADD:  state_q <= S_UP;
							OP_SUB:  state_q <= S_DN;
							default: state_q <= S_DIVQ;
						endcase
					end
				end
				S_DIVQ: state_q <= S_DIVR;
				S_DIVR: state_q <= S_CHK;
				S_CHK: begin
					if (op_q == OP_LOAD) begin
						if (opd_ok) begin
							held_q <= opd_q;
							hdv_q  <= opd_dv;
						end else begin
							held_q.year  <= '0;
							held_q.month <= MONTH_W'(1);
							held_q.day   <= DAY_W'(1);
							hdv_q        <= '0;
							err_q        <= 1'b1;
						end
						state_q <= S_OUT;
					end else if (opd_ok) begin
						state_q <= S_SO_A;
					end else begin
						err_q   <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_UP: begin
					if (cnt_q == '0) begin
						state_q <= S_OUT;
					end else if (at_top) begin
						err_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q - COUNT_W'(1);
						if (held_q.day < held_mlen) begin
							held_q.day <= held_q.day + DAY_W'(1);
						end else begin
							held_q.day <= DAY_W'(1);
							if (held_q.month < MONTH_W'(12)) begin
								held_q.month <= held_q.month + MONTH_W'(1);
							end else begin
								held_q.month <= MONTH_W'(1);
								held_q.year  <= held_q.year + YEAR_W'(1);
								if (hdv_q.r == R100_W'(99)) begin
									hdv_q.r <= '0;
									hdv_q.q <= hdv_q.q + Q100_W'(1);
								end else begin
									hdv_q.r <= hdv_q.r + R100_W'(1);
								end
							end
						end
					end
				end
				S_DN: begin
					if (cnt_q == '0) begin
						state_q <= S_OUT;
					end else if (at_bottom) begin
						err_q   <= 1'b1;
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q - COUNT_W'(1);
						if (held_q.day > DAY_W'(1)) begin
							held_q.day <= held_q.day - DAY_W'(1);
						end else if (held_q.month > MONTH_W'(1)) begin
							held_q.month <= held_q.month - MONTH_W'(1);
							held_q.day   <= prev_mlen;
						end else begin
							held_q.month <= MONTH_W'(12);
							held_q.day   <= DAY_W'(31);
							held_q.year  <= held_q.year - YEAR_W'(1);
							if (hdv_q.r == '0) begin
								hdv_q.r <= R100_W'(99);
								hdv_q.q <= hdv_q.q - Q100_W'(1);
							end else begin
								hdv_q.r <= hdv_q.r - R100_W'(1);
							end
						end
					end
				end
				S_SO_A: state_q <= S_SO_B;
				S_SO_B: begin
					so_q    <= ser_out;
					state_q <= S_SH_A;
				end
				S_SH_A: state_q <= S_SH_B;
				S_SH_B: begin
					sh_q    <= ser_out;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					apart_q <= gap_days[APART_W-1:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					// wait for the output register to free up
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= M_TDATA_W'({apart_q, held_q.year, held_q.month,
							held_q.day});
						m_err_q    <= err_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_err_q;

`ifndef NO_ASSERTIONS
	// held date always carries a real month
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q.month >= MONTH_W'(1)) && (held_q.month <= MONTH_W'(12)))
		else $error("held month out of range");

	// century counters track the held year
	a_year_split: assert property (@(posedge clk) disable iff (!arst_n)
		(hdv_q.r < R100_W'(100)) &&
		(YEAR_W'(hdv_q.q) * YEAR_W'(100) + YEAR_W'(hdv_q.r) == held_q.year))
		else $error("year/100 counters out of step with held year");

	// a result only appears out of the output state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_OUT))
		else $error("result word raised outside output state");

	// stepping never moves the held date past the upper limit
	a_year_limit: assert property (@(posedge clk) disable iff (!arst_n)
		held_q.year <= MaxYear)
		else $error("held year above limit");
`endif

endmodule

// ===== test/calendar_date_stepper_tb.sv =====
// ----------------------------------------------------------------------------
// calendar_date_stepper_tb
// Self-checking bench for the Gregorian date stepper.
// ----------------------------------------------------------------------------
// Drives command words (load, add, subtract, difference) through the slave
// stream in random bursts while the master side stalls on its own pattern.
// A calendar model in the bench follows the held date and predicts every
// result word, which is checked field by field. Directed tests cover invalid
// dates, leap and century rules and both range limits; a random mix follows.
// ----------------------------------------------------------------------------
module calendar_date_stepper_tb
	import cds_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TOP_YEAR  = MAX_YEAR_DEF;
	localparam int unsigned IDLE_LIMIT = 4_500_000;   // longest walk plus stalls
	localparam int unsigned TAIL_CYCLES = 20;

	typedef enum logic [1:0] {
		RX_OPEN   = 2'd0,
		RX_ALT    = 2'd1,
		RX_SPARSE = 2'd2,
		RX_RANDOM = 2'd3
	} rx_mode_e;

	typedef struct {
		date_t             held;
		logic [APART_W-1:0] apart;
		logic              err;
	} date_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [0:0]           m_tuser;

	date_t       held_model;
	date_reply_t expected_dates[$];
	int unsigned mismatch_count = 0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	logic [7:0]  rx_phase = '0;
	rx_mode_e    rx_mode = RX_OPEN;

	calendar_date_stepper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- calendar model ----------------

	function automatic bit leap_yr(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		case (m)
			2: return leap_yr(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default: return 0;
		endcase
	endfunction

	function automatic bit date_valid(input int unsigned d, input int unsigned m,
			input int unsigned y);
		if (m < 1 || m > 12 || y > TOP_YEAR) begin
			return 1'b0;
		end
		return (d >= 1) && (d <= month_days(y, m));
	endfunction

	// days in all years before y, year 0 first
	function automatic int unsigned days_to_year(input int unsigned y);
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	// 1/1/0 is day 0
	function automatic int unsigned day_index(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned s;
		s = days_to_year(y);
		for (int unsigned k = 1; k < m && k <= 12; k++) begin
			s += month_days(y, k);
		end
		return s + d - 1;
	endfunction

	function automatic date_t date_from_index(input int unsigned s);
		int unsigned y;
		int unsigned r;
		int unsigned m;
		date_t       res;
		y = (s / 146097) * 400;
		r = s - days_to_year(y);
		while (r >= 365 + leap_yr(y)) begin
			r -= 365 + leap_yr(y);
			y++;
		end
		m = 1;
		while (m < 12 && r >= month_days(y, m)) begin
			r -= month_days(y, m);
			m++;
		end
		res.year  = YEAR_W'(y);
		res.month = MONTH_W'(m);
		res.day   = DAY_W'(r + 1);
		return res;
	endfunction

	// applies one command to the held date and returns the word it should produce
	function automatic date_reply_t step_held_date(input opcode_t op, input int unsigned d,
			input int unsigned m, input int unsigned y, input int unsigned cnt);
		date_reply_t rep;
		int unsigned cur;
		int unsigned top;
		int unsigned tgt;
		int unsigned other;
		rep.apart = '0;
		rep.err   = 1'b0;
		cur = day_index(held_model.day, held_model.month, held_model.year);
		top = days_to_year(TOP_YEAR + 1) - 1;
		case (op)
			OP_LOAD: begin
				if (date_valid(d, m, y)) begin
					held_model.day   = DAY_W'(d);
					held_model.month = MONTH_W'(m);
					held_model.year  = YEAR_W'(y);
				end else begin
					held_model = date_from_index(0);
					rep.err = 1'b1;
				end
			end
			OP_ADD: begin
				tgt = cur + cnt;
				if (tgt > top) begin
					tgt = top;
					rep.err = 1'b1;
				end
				held_model = date_from_index(tgt);
			end
			OP_SUB: begin
				if (cnt > cur) begin
					tgt = 0;
					rep.err = 1'b1;
				end else begin
					tgt = cur - cnt;
				end
				held_model = date_from_index(tgt);
			end
			default: begin
				if (date_valid(d, m, y)) begin
					other = day_index(d, m, y);
					rep.apart = APART_W'((other > cur) ? other - cur : cur - other);
				end else begin
					rep.err = 1'b1;
				end
			end
		endcase
		rep.held = held_model;
		return rep;
	endfunction

	// ---------------- stimulus ----------------

	// one command word; sender idles between bursts of random length
	task automatic send_cmd(input opcode_t op, input int unsigned d, input int unsigned m,
			input int unsigned y, input int unsigned cnt);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			burst_left = $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= S_TDATA_W'({COUNT_W'(cnt), YEAR_W'(y), MONTH_W'(m), DAY_W'(d)});
		do @(posedge clk); while (!s_tready);
		expected_dates.push_back(step_held_date(op, d & 5'h1F, m & 4'hF, y & 14'h3FFF,
			cnt & 20'hFFFFF));
	endtask

	task automatic test_reset_state();
		send_cmd(OP_DIFF, 1, 1, 0, 20'hFFFFF);      // held date should be 1/1/0
	endtask

	task automatic test_load_checks();
		send_cmd(OP_LOAD, 0, 0, 0, 0);              // all zero: invalid
		send_cmd(OP_LOAD, 31, 15, 16383, 20'hFFFFF); // all ones: invalid
		send_cmd(OP_LOAD, 29, 2, 1900, 0);          // century, not leap
		send_cmd(OP_LOAD, 29, 2, 2000, 0);          // 400 rule, leap
		send_cmd(OP_ADD, 0, 0, 0, 1);
		send_cmd(OP_LOAD, 31, 4, 2023, 0);          // day past month end
		send_cmd(OP_LOAD, 1, 1, TOP_YEAR + 1, 0);   // year above range
		send_cmd(OP_LOAD, 28, 2, 2100, 0);
		send_cmd(OP_ADD, 0, 0, 0, 1);               // 2100 has no 29th
	endtask

	task automatic test_stepping();
		send_cmd(OP_LOAD, 31, 12, 1999, 0);
		send_cmd(OP_ADD, 7, 7, 7, 1);               // year rollover
		send_cmd(OP_SUB, 0, 0, 0, 1);
		send_cmd(OP_ADD, 0, 0, 0, 0);               // zero count
		send_cmd(OP_LOAD, 3, 1, 0, 0);
		send_cmd(OP_SUB, 0, 0, 0, 2);               // lands on the bottom exactly
		send_cmd(OP_SUB, 0, 0, 0, 1);               // past the bottom
		send_cmd(OP_SUB, 0, 0, 0, 20'hFFFFF);
		send_cmd(OP_LOAD, 30, 12, TOP_YEAR, 0);
		send_cmd(OP_ADD, 0, 0, 0, 1);               // lands on the top exactly
		send_cmd(OP_ADD, 0, 0, 0, 1);               // past the top
		send_cmd(OP_LOAD, 1, 1, TOP_YEAR, 0);
		send_cmd(OP_ADD, 0, 0, 0, 20'hFFFFF);       // clamps after one year
		// long walk over 1900, 2000 and 2400
		send_cmd(OP_LOAD, 28, 2, 1896, 0);
		send_cmd(OP_ADD, 0, 0, 0, 300000);
	endtask

	task automatic test_difference();
		send_cmd(OP_LOAD, 31, 12, TOP_YEAR, 0);
		send_cmd(OP_DIFF, 1, 1, 0, 0);              // widest distance
		send_cmd(OP_DIFF, 30, 2, 2000, 0);          // invalid operand
		send_cmd(OP_LOAD, 15, 6, 1600, 0);
		send_cmd(OP_DIFF, 15, 6, 2400, 0);
	endtask

	// operand date, mostly valid, biased to the range ends and century years
	task automatic random_operand(output int unsigned d, output int unsigned m,
			output int unsigned y);
		int unsigned k;
		k = $urandom_range(0, 9);
		case (k)
			0, 1: y = $urandom_range(0, 3);
			2, 3: y = $urandom_range(TOP_YEAR - 3, TOP_YEAR);
			4: y = $urandom_range(0, 16383);
			5: y = 100 * $urandom_range(0, 99);
			default: y = $urandom_range(0, TOP_YEAR);
		endcase
		m = $urandom_range(1, 12);
		d = ($urandom_range(0, 4) == 0) ? month_days(y, m) : $urandom_range(1, month_days(y, m));
		if ($urandom_range(0, 9) == 0) begin
			d = $urandom_range(0, 31);
			m = $urandom_range(0, 15);
		end
	endtask

	// day count; full-width counts only where the walk is short
	function automatic int unsigned pick_step(inout opcode_t op);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10 && held_model.year <= 2) begin
			op = OP_SUB;
			return $urandom_range(0, 20'hFFFFF);
		end
		if (r < 10 && held_model.year >= TOP_YEAR - 2) begin
			op = OP_ADD;
			return $urandom_range(0, 20'hFFFFF);
		end
		if (r < 20) begin
			return $urandom_range(0, 20000);
		end
		if (r < 35) begin
			return $urandom_range(0, 2000);
		end
		return (r == 99) ? 0 : $urandom_range(0, 400);
	endfunction

	task automatic test_random_mix();
		int unsigned pick;
		int unsigned d;
		int unsigned m;
		int unsigned y;
		int unsigned cnt;
		opcode_t     op;
		repeat (70) begin
			pick = $urandom_range(0, 99);
			random_operand(d, m, y);
			cnt = $urandom_range(0, 20'hFFFFF);
			if (pick < 25) begin
				op = OP_LOAD;
			end else if (pick < 45) begin
				op = OP_DIFF;
			end else begin
				op = (pick < 72) ? OP_ADD : OP_SUB;
				cnt = pick_step(op);
			end
			send_cmd(op, d, m, y, cnt);
		end
	endtask

	// ---------------- result side ----------------

	// stall pattern changes each time the low six bits of the phase counter are zero
	always @(posedge clk) begin
		rx_phase <= rx_phase + 8'd1;
		if (rx_phase[5:0] == 6'd0) begin
			rx_mode <= rx_mode_e'($urandom_range(0, 3));
		end
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_ALT:    m_tready <= rx_phase[0];
			RX_SPARSE: m_tready <= (rx_phase[1:0] == 2'd3);
			default:   m_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		$display("%0t mismatch %s: got %0d, expected %0d", $realtime, field, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		date_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_dates.size() == 0) begin
				report_mismatch("unexpected word, day", m_tdata[4:0], 0);
			end else begin
				want = expected_dates.pop_front();
				if (m_tdata[4:0] !== want.held.day)
					report_mismatch("cur_day", m_tdata[4:0], want.held.day);
				if (m_tdata[8:5] !== want.held.month)
					report_mismatch("cur_month", m_tdata[8:5], want.held.month);
				if (m_tdata[22:9] !== want.held.year)
					report_mismatch("cur_year", m_tdata[22:9], want.held.year);
				if (m_tdata[44:23] !== want.apart)
					report_mismatch("days_apart", m_tdata[44:23], want.apart);
				if (m_tuser[0] !== want.err)
					report_mismatch("error_flag", m_tuser[0], want.err);
			end
		end
	end

	// ends the run when no word moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		held_model = date_from_index(0);
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);
		test_reset_state();
		test_load_checks();
		test_stepping();
		test_difference();
		test_random_mix();
		s_tvalid <= 1'b0;
		while (expected_dates.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/cds_pkg.sv
sv/cds_div100.sv
sv/cds_serial.sv
sv/calendar_date_stepper.sv
test/calendar_date_stepper_tb.sv
